/* rtl/ewsh_pkg.sv */
// shared types, constants and the slot update function of the eight word stream hash
package ewsh_pkg;

  localparam int unsigned SlotCount = 8;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 2;

  typedef logic [SlotCount-1:0][WordW-1:0] word_arr_t;

  // input beat: one byte of the stream
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_beat_t;

  // output beat: one digest word
  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [SlotW-1:0] word_index;
    logic             last_word;
  } out_beat_t;

  typedef enum logic [1:0] {
    OP_XOR,
    OP_XNOT,
    OP_ORNOT
  } slot_op_e;

  localparam word_arr_t INIT_WORDS = {
    32'hE21B5202, 32'hDF4BD379, 32'hEFB7A415, 32'hEFE83F42,
    32'h832459EC, 32'hC829A0B9, 32'hFF206483, 32'hB9D1FBFD
  };

  localparam word_arr_t ZERO_SUBST = {
    32'hD46DC441, 32'h6D800AE8, 32'hDA4AC801, 32'h1FEE62AD,
    32'h92F80685, 32'h634DE5A3, 32'h84014006, 32'hC5A14356
  };

  localparam slot_op_e SLOT_OP [SlotCount] = '{
    OP_XOR, OP_XNOT, OP_XOR, OP_ORNOT,
    OP_XNOT, OP_ORNOT, OP_XOR, OP_ORNOT
  };

  // new value of one hash slot for a finished word
  function automatic logic [WordW-1:0] slot_update(logic [SlotW-1:0] slot,
                                                   logic [WordW-1:0] old_word,
                                                   logic [WordW-1:0] new_word);
    logic [WordW-1:0] res;
    if (new_word == '0) begin
      res = ZERO_SUBST[slot];
    end else begin
      case (SLOT_OP[slot])
        OP_XOR:   res = new_word ^ old_word;
        OP_XNOT:  res = new_word ^ ~old_word;
        OP_ORNOT: res = new_word | ~old_word;
        default:  res = new_word ^ old_word;
      endcase
    end
    return res;
  endfunction

endpackage

/* rtl/ewsh_digest_out.sv */
// digest output buffer: holds the eight finished words and sends them one beat at a time
module ewsh_digest_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ewsh_pkg::word_arr_t words_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output ewsh_pkg::out_beat_t out_data_o,
  input  logic               out_stall_i
);
  import ewsh_pkg::*;

  word_arr_t        words_q;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             busy_q, busy_d;
  logic             out_take;
  logic             at_last;

  assign at_last  = (idx_q == SlotW'(SlotCount - 1));
  assign out_take = busy_q && !out_stall_i;

  // word counter and buffer state
  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (out_take) begin
      idx_d = idx_q + 1'b1;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  // snapshot of the digest
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end
  end

  assign busy_o                 = busy_q;
  assign out_valid_o            = busy_q;
  assign out_data_o.digest_word = words_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = at_last;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_q)
    else $error("digest loaded while previous digest still pending");
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_valid_o && (out_data_o.word_index == '0))
    else $error("digest did not start at word zero");
  a_keep_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !at_last |=> out_valid_o)
    else $error("digest stopped before its final word");
  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && at_last && !load_i |=> !out_valid_o)
    else $error("digest kept sending after its final word");
`endif

endmodule

/* rtl/eight_word_stream_hash.sv */
// top level of the eight word stream hash
//
// Input channel: one beat carries one byte of a file in data_byte, with
// last_byte high on the file's final byte. Bytes pack most significant
// first into 32-bit words; each finished word updates the next of eight
// hash slots in rotation. A partial word at the end is padded with 0xFF.
// Output channel: after a last byte the eight hash words leave as eight
// beats, word_index 0 to 7, last_word high on the eighth.
// Throughput: one byte per cycle while in_stall_o is low; each byte is packed
// and any word update done in the same cycle it is accepted. The digest
// appears on the output in the cycle after the last byte is accepted and
// drains through the output buffer one word per cycle while not stalled.
// While a digest drains, bytes of the next file are still accepted; only
// a further last byte is stalled until the buffer has emptied.
// A stalled output holds its beat; the hash keeps running behind it.
// Reset: the hash slots return to their initial constants, the byte
// position and slot rotation to zero and the output buffer empties.
module eight_word_stream_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ewsh_pkg::in_beat_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output ewsh_pkg::out_beat_t out_data_o,
  input  logic                out_stall_i
);
  import ewsh_pkg::*;

  logic [WordW-1:0] acc_q, acc_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [SlotW-1:0] slot_q, slot_d;
  word_arr_t        hash_q, hash_d;
  word_arr_t        hash_upd;
  logic [WordW-1:0] byte_word;
  logic [WordW-1:0] pad_mask;
  logic [WordW-1:0] full_word;
  logic             word_done;
  logic             in_take;
  logic             load;
  logic             out_busy;

  // only a last byte waits for the output buffer
  assign in_stall_o = out_busy && in_valid_i && in_data_i.last_byte;
  assign in_take    = in_valid_i && !in_stall_o;
  assign load       = in_take && in_data_i.last_byte;

  // place the byte and work out the padding for a short final word
  assign byte_word = {{(WordW-ByteW){1'b0}}, in_data_i.data_byte}
                     << (ByteW * (3 - 32'(pos_q)));
  assign pad_mask  = in_data_i.last_byte ?
                     ({WordW{1'b1}} >> (ByteW * (32'(pos_q) + 1))) : '0;
  assign full_word = acc_q | byte_word | pad_mask;
  assign word_done = (pos_q == PosW'(3)) || in_data_i.last_byte;

  // hash slots with this beat's word applied
  always_comb begin
    hash_upd = hash_q;
    if (word_done) begin
      hash_upd[slot_q] = slot_update(slot_q, hash_q[slot_q], full_word);
    end
  end

  // next state of the packer and hash
  always_comb begin
    acc_d  = acc_q;
    pos_d  = pos_q;
    slot_d = slot_q;
    hash_d = hash_q;
    if (in_take) begin
      if (in_data_i.last_byte) begin
        acc_d  = '0;
        pos_d  = '0;
        slot_d = '0;
        hash_d = INIT_WORDS;
      end else if (word_done) begin
        acc_d  = '0;
        pos_d  = '0;
        slot_d = slot_q + 1'b1;
        hash_d = hash_upd;
      end else begin
        acc_d = acc_q | byte_word;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= '0;
      slot_q <= '0;
      hash_q <= INIT_WORDS;
    end else begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      slot_q <= slot_d;
      hash_q <= hash_d;
    end
  end

  ewsh_digest_out u_digest_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .words_i     (hash_upd),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_i && in_data_i.last_byte && out_valid_o)
    else $error("input stalled without a pending last byte");
  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (pos_q == '0) && (slot_q == '0) && (acc_q == '0))
    else $error("packer not cleared after a last byte");
  a_digest_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("no digest after a last byte");
`endif

endmodule

/* tb/sv/eight_word_stream_hash_test.sv */
// self-checking testbench for the eight word stream hash: byte files in, digest beats checked
module eight_word_stream_hash_test;
  import ewsh_pkg::*;

  // slot constants and per-slot update operation
  localparam logic [31:0] HASH_INIT [8] = '{
    32'hB9D1FBFD, 32'hFF206483, 32'hC829A0B9, 32'h832459EC,
    32'hEFE83F42, 32'hEFB7A415, 32'hDF4BD379, 32'hE21B5202
  };
  localparam logic [31:0] ZERO_LOAD [8] = '{
    32'hC5A14356, 32'h84014006, 32'h634DE5A3, 32'h92F80685,
    32'h1FEE62AD, 32'hDA4AC801, 32'h6D800AE8, 32'hD46DC441
  };
  localparam slot_op_e SLOT_KIND [8] = '{
    OP_XOR, OP_XNOT, OP_XOR, OP_ORNOT,
    OP_XNOT, OP_ORNOT, OP_XOR, OP_ORNOT
  };
  localparam int unsigned RandomBytes = 385;
  localparam int unsigned TailBytes   = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  in_beat_t  in_data_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_data_o;
  logic      out_stall_i;

  // hash state mirror
  logic [31:0] hash_slot [8];
  logic [31:0] hash_acc;
  logic [1:0]  hash_pos;
  logic [2:0]  hash_ptr;

  out_beat_t   digest_q [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  eight_word_stream_hash u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // back to the initial constants
  task automatic clear_hash_state();
    for (int k = 0; k < 8; k++) hash_slot[k] = HASH_INIT[k];
    hash_acc = '0;
    hash_pos = '0;
    hash_ptr = '0;
  endtask

  // fold one finished word into the current slot and advance the rotation
  task automatic fold_word(input logic [31:0] w);
    logic [31:0] prev;
    prev = hash_slot[hash_ptr];
    if (w == '0) begin
      hash_slot[hash_ptr] = ZERO_LOAD[hash_ptr];
    end else begin
      case (SLOT_KIND[hash_ptr])
        OP_XOR:   hash_slot[hash_ptr] = w ^ prev;
        OP_XNOT:  hash_slot[hash_ptr] = w ^ ~prev;
        default:  hash_slot[hash_ptr] = w | ~prev;
      endcase
    end
    hash_ptr = hash_ptr + 3'd1;
  endtask

  // expected digest beats for one accepted byte
  task automatic hash_byte(input in_beat_t beat);
    int unsigned p;
    out_beat_t   r;
    p = 32'(hash_pos);
    hash_acc = hash_acc | ({24'h0, beat.data_byte} << (8 * (3 - p)));
    p++;
    if (p == 4 || beat.last_byte) begin
      // pad a partial final word with 0xff bytes
      while (p < 4) begin
        hash_acc = hash_acc | (32'hFF << (8 * (3 - p)));
        p++;
      end
      fold_word(hash_acc);
      hash_acc = '0;
      p = 0;
    end
    hash_pos = p[1:0];
    if (beat.last_byte) begin
      for (int k = 0; k < 8; k++) begin
        r.digest_word = hash_slot[k];
        r.word_index  = k[2:0];
        r.last_word   = (k == 7);
        digest_q.push_back(r);
      end
      clear_hash_state();
    end
  endtask

  // send one byte beat; called at a rising edge, returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_beat_t beat;
    bit       taken;
    beat.data_byte = b;
    beat.last_byte = lst;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    hash_byte(beat);
    bytes_sent++;
  endtask

  // one file of len bytes; fill 0 random, 1 mostly zero, 2 mostly 0xff
  task automatic send_file(input int unsigned len, input int unsigned fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (fill == 1 && $urandom_range(0, 3) != 0) b = 8'h00;
      if (fill == 2 && $urandom_range(0, 3) != 0) b = 8'hFF;
      send_byte(b, i == len - 1);
    end
  endtask

  // files of one to four bytes: padding of three, two, one and no bytes
  task automatic test_partial_words();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
  endtask

  // all-zero word loads the substitute, all-ones word, then a padded zero byte
  task automatic test_zero_and_full_words();
    for (int i = 0; i < 4; i++) send_byte(8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // random files, some long enough to wrap the slot rotation
  task automatic test_random_files();
    int unsigned goal;
    int unsigned len;
    goal = bytes_sent + RandomBytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(33, 72);
      else len = $urandom_range(1, 40);
      send_file(len, $urandom_range(0, 2));
    end
  endtask

  // no idling: short files back to back, last bytes meeting a draining digest
  task automatic test_back_to_back();
    int unsigned goal;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    goal = bytes_sent + TailBytes;
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
    while (bytes_sent < goal) send_file($urandom_range(1, 9), $urandom_range(0, 2));
  endtask

  // output stall bursts
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (rx_gaps_on) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  // digest beat checker, sampled away from the clock edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest beat with none expected: word %h index %0d last %b",
                 $time, out_data_o.digest_word, out_data_o.word_index,
                 out_data_o.last_word);
        mismatches++;
      end else begin
        if (out_data_o.digest_word !== digest_q[0].digest_word ||
            out_data_o.word_index  !== digest_q[0].word_index ||
            out_data_o.last_word   !== digest_q[0].last_word) begin
          $display("%0t: digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                   $time, digest_q[0].digest_word, digest_q[0].word_index,
                   digest_q[0].last_word, out_data_o.digest_word,
                   out_data_o.word_index, out_data_o.last_word);
          mismatches++;
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    clear_hash_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_partial_words();
    test_zero_and_full_words();
    test_random_files();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
